[rtl/assert_macros.svh]
// Assertion macros for the RTL of the Plummer sphere evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/ppf_pkg.sv]
// Package with widths, constants and word types of the Plummer sphere evaluator.
package ppf_pkg;

	// Field widths.
	localparam int COORD_WIDTH = 32;
	localparam int GRAD_W      = 48;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 2;

	// Fraction shifts of the fixed-point formulas.
	localparam int ROOT_SHIFT = 32;
	localparam int POT_SHIFT  = 16;
	localparam int GRAD_SHIFT = 32;
	localparam int DENS_SHIFT = 48;

	// Internal widths.
	localparam int SQR_W      = 2 * COORD_WIDTH;
	localparam int SUM_W      = ((SQR_W > 2 * CFG_W) ? SQR_W : 2 * CFG_W) + 2;
	localparam int ROOT_W     = (SUM_W + ROOT_SHIFT + 1) / 2;
	localparam int GM_W       = 2 * CFG_W;
	localparam int POT_NUM_W  = GM_W + POT_SHIFT;
	localparam int D1_W       = SUM_W + ROOT_W;
	localparam int GMX_W      = GM_W + COORD_WIDTH;
	localparam int GRAD_NUM_W = GMX_W + GRAD_SHIFT;
	localparam int D2_W       = D1_W + SUM_W;
	localparam int KMB_W      = GM_W + 2 * CFG_W;
	localparam int DENS_NUM_W = KMB_W + DENS_SHIFT;

	// Quotient bits kept by each divider; larger quotients raise overflow.
	localparam int POT_QB  = GRAD_W - 1;
	localparam int GRAD_QB = GRAD_W;
	localparam int DENS_QB = GRAD_W;

	// Multiplier latency and settle time of the derived constants.
	localparam int MUL_LAT    = 3;
	localparam int CFG_SETTLE = 2 * MUL_LAT;
	localparam int SETTLE_W   = $clog2(CFG_SETTLE + 1);

	// round(3/(4*pi) * 2^32).
	localparam logic [CFG_W-1:0] DENS_K    = 32'd1025347913;
	localparam logic [CFG_W-1:0] CFG_RESET = 32'd65536;

	// Saturation limits.
	localparam logic [GRAD_W-1:0]        POT_LIMIT  = {1'b1, {(GRAD_W - 1){1'b0}}};
	localparam logic [GRAD_W:0]          TERM_LIMIT = {1'b1, {GRAD_W{1'b0}}};
	localparam logic signed [GRAD_W-1:0] GRAD_MAX   = {1'b0, {(GRAD_W - 1){1'b1}}};
	localparam logic signed [GRAD_W-1:0] GRAD_MIN   = {1'b1, {(GRAD_W - 1){1'b0}}};

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRAV  = 2'd0,
		CFG_MASS  = 2'd1,
		CFG_SCALE = 2'd2
	} cfg_idx_t;

	// Input word.
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic signed [COORD_WIDTH-1:0] pos_z;
		logic signed [GRAD_W-1:0]      grad_in_x;
		logic signed [GRAD_W-1:0]      grad_in_y;
		logic signed [GRAD_W-1:0]      grad_in_z;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic signed [GRAD_W-1:0] potential;
		logic signed [GRAD_W-1:0] grad_out_x;
		logic signed [GRAD_W-1:0] grad_out_y;
		logic signed [GRAD_W-1:0] grad_out_z;
		logic [GRAD_W-1:0]        density;
		logic                     div_fault;
	} out_word_t;

endpackage

[rtl/ppf_dly.sv]
// Fixed-depth delay line that keeps side data aligned with the arithmetic pipeline.
module ppf_dly #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_q [DEPTH];

	// Shift one tap per cycle.
	always_ff @(posedge clk) begin
		tap_q[0] <= d;
		for (int i = 1; i < DEPTH; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

[rtl/ppf_mul.sv]
// Three-stage unsigned multiplier built from 32 by 32 bit partial products.
module ppf_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic             clk,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p
);

	localparam int DIG = 32;
	localparam int NA  = (AW + DIG - 1) / DIG;
	localparam int NB  = (BW + DIG - 1) / DIG;
	localparam int AP  = NA * DIG;
	localparam int BP  = NB * DIG;
	localparam int RW  = (NB + 1) * DIG;
	localparam int PW  = (NA + NB) * DIG;

	logic [AP-1:0]      a_pad;
	logic [BP-1:0]      b_pad;
	logic [2*DIG-1:0]   pp_s1 [NA][NB];
	logic [RW-1:0]      row_c [NA];
	logic [RW-1:0]      row_s2 [NA];
	logic [PW-1:0]      prod_c;
	logic [PW-1:0]      prod_s3;

	assign a_pad = AP'(a);
	assign b_pad = BP'(b);

	// Digit products.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s1[i][j] <= a_pad[i*DIG +: DIG] * b_pad[j*DIG +: DIG];
			end
		end
	end

	// Sum each row of partial products.
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (RW'(pp_s1[i][j]) << (j * DIG));
			end
		end
	end

	always_ff @(posedge clk) begin
		row_s2 <= row_c;
	end

	// Sum the rows.
	always_comb begin
		prod_c = '0;
		for (int i = 0; i < NA; i++) begin
			prod_c = prod_c + (PW'(row_s2[i]) << (i * DIG));
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= prod_c;
	end

	assign p = prod_s3[AW+BW-1:0];

endmodule

[rtl/ppf_sqrt.sv]
// Pipelined integer square root of a shifted input, one root bit per stage.
module ppf_sqrt #(
	parameter int IW    = 66,
	parameter int SHIFT = 32,
	parameter int RW    = 49
) (
	input  logic          clk,
	input  logic [IW-1:0] s,
	output logic [RW-1:0] root
);

	localparam int RADW = 2 * RW;
	localparam int REMW = RW + 2;

	logic [RADW-1:0] rad_in;
	logic [RADW-1:0] rad_s  [RW];
	logic [REMW-1:0] rem_s  [RW];
	logic [RW-1:0]   root_s [RW];

	assign rad_in = RADW'({s, {SHIFT{1'b0}}});

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RADW-1:0] rad_p;
		logic [REMW-1:0] rem_p;
		logic [RW-1:0]   root_p;
		logic [REMW-1:0] cur;
		logic [REMW-1:0] trial;

		if (k == 0) begin : g_first
			assign rad_p  = rad_in;
			assign rem_p  = '0;
			assign root_p = '0;
		end else begin : g_next
			assign rad_p  = rad_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
		end

		// Bring down the next two radicand bits and try the next root bit.
		always_comb begin
			cur   = {rem_p[REMW-3:0], rad_p[RADW-1 -: 2]};
			trial = {root_p, 2'b01};
		end

		always_ff @(posedge clk) begin
			rad_s[k] <= rad_p << 2;
			if (cur >= trial) begin
				rem_s[k]  <= cur - trial;
				root_s[k] <= {root_p[RW-2:0], 1'b1};
			end else begin
				rem_s[k]  <= cur;
				root_s[k] <= {root_p[RW-2:0], 1'b0};
			end
		end
	end

	assign root = root_s[RW-1];

endmodule

[rtl/ppf_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module ppf_div #(
	parameter int NW = 80,
	parameter int DW = 49,
	parameter int QB = 47
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QB-1:0] quo,
	output logic          ovf
);

	localparam int HW = NW - QB;
	localparam int CW = (HW > DW) ? HW : DW;

	logic [HW-1:0] hi;
	logic          ovf_c;
	logic [DW-1:0] rem_s [QB+1];
	logic [QB-1:0] lo_s  [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic          ovf_s [QB+1];

	// The quotient does not fit in QB bits when the upper part reaches the divisor.
	assign hi    = num[NW-1:QB];
	assign ovf_c = (CW'(hi) >= CW'(den));

	always_ff @(posedge clk) begin
		ovf_s[0] <= ovf_c;
		rem_s[0] <= ovf_c ? '0 : DW'(hi);
		lo_s[0]  <= num[QB-1:0];
		den_s[0] <= den;
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [DW:0] cur;
		logic [DW:0] diff;
		logic        take;

		// Shift in the next numerator bit and subtract where it fits.
		always_comb begin
			cur  = {rem_s[k-1], lo_s[k-1][QB-1]};
			diff = cur - {1'b0, den_s[k-1]};
			take = (cur >= {1'b0, den_s[k-1]});
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= take ? diff[DW-1:0] : cur[DW-1:0];
			lo_s[k]  <= {lo_s[k-1][QB-2:0], take};
			den_s[k] <= den_s[k-1];
			ovf_s[k] <= ovf_s[k-1];
		end
	end

	assign quo = lo_s[QB];
	assign ovf = ovf_s[QB];

endmodule

[rtl/plummer_potential_force_eval.sv]
// Top level of the Plummer sphere potential, density and force evaluator.
//
// channel   direction  handshake                 word
// operand   in         start & !busy             ppf_pkg::in_word_t
// result    out        done, one cycle strobe    ppf_pkg::out_word_t
// cfg       in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// One word is accepted per cycle while busy is low. Most of the pipeline lies in
// the 49-stage square root and the 49-stage density divider, with the input register,
// the three-stage multipliers and the output register.
// After reset and after each configuration write, busy stays high while the derived
// constants G*m, b*b and K*m*b*b pass through their multipliers.
// The result side has no backpressure, so the pipeline never stalls.
`include "assert_macros.svh"

module plummer_potential_force_eval (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  ppf_pkg::in_word_t                operand,
	output logic                             done,
	output ppf_pkg::out_word_t               result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ppf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ppf_pkg::CFG_W-1:0]        cfg_data
);

	localparam int W      = ppf_pkg::COORD_WIDTH;
	localparam int GW     = ppf_pkg::GRAD_W;
	localparam int ACC_W  = GW + 2;
	localparam int SIDE_W = 3 + 3 * GW;

	// Stage at which each intermediate value is available.
	localparam int T_SQ  = 1 + ppf_pkg::MUL_LAT;
	localparam int T_S   = T_SQ + 1;
	localparam int T_Q   = T_S + ppf_pkg::ROOT_W;
	localparam int T_POT = T_Q + ppf_pkg::POT_QB + 1;
	localparam int T_D1  = T_Q + ppf_pkg::MUL_LAT;
	localparam int T_GMX = 1 + ppf_pkg::MUL_LAT;
	localparam int T_GR  = T_D1 + ppf_pkg::GRAD_QB + 1;
	localparam int T_D2  = T_D1 + ppf_pkg::MUL_LAT;
	localparam int T_DN  = T_D2 + ppf_pkg::DENS_QB + 1;

	// Configuration registers and settle counter.
	logic [ppf_pkg::CFG_W-1:0]    grav_q;
	logic [ppf_pkg::CFG_W-1:0]    mass_q;
	logic [ppf_pkg::CFG_W-1:0]    scale_q;
	logic [ppf_pkg::SETTLE_W-1:0] settle_q;
	logic                         cfg_wr;
	logic                         accept;

	// Derived constants.
	logic [ppf_pkg::GM_W-1:0]  gm;
	logic [ppf_pkg::GM_W-1:0]  km;
	logic [ppf_pkg::GM_W-1:0]  b2;
	logic [ppf_pkg::KMB_W-1:0] kmb2;

	// Item pipeline.
	logic signed [W-1:0]   pos_c  [3];
	logic signed [GW-1:0]  gin_c  [3];
	logic [W-1:0]          mag_s1 [3];
	logic                  neg_s1 [3];
	logic signed [GW-1:0]  gin_s1 [3];
	logic [SIDE_W-1:0]     side_in;
	logic [SIDE_W-1:0]     side_dn;
	logic [ppf_pkg::SQR_W-1:0]  sq  [3];
	logic [ppf_pkg::GMX_W-1:0]  gmx [3];
	logic [ppf_pkg::GMX_W-1:0]  gmx_d1 [3];
	logic [ppf_pkg::SUM_W-1:0]  sum_c;
	logic [ppf_pkg::SUM_W-1:0]  sum_s5;
	logic                       zero_s5;
	logic                       zero_dn;
	logic [ppf_pkg::ROOT_W-1:0] root;
	logic [ppf_pkg::SUM_W-1:0]  sum_q_al;
	logic [ppf_pkg::SUM_W-1:0]  sum_d1_al;
	logic [ppf_pkg::D1_W-1:0]   d1;
	logic [ppf_pkg::D2_W-1:0]   d2;
	logic [ppf_pkg::POT_QB-1:0] pot_q;
	logic                       pot_ovf;
	logic [ppf_pkg::POT_QB:0]   pot_dn;
	logic [ppf_pkg::GRAD_QB-1:0] gr_q  [3];
	logic                        gr_ovf [3];
	logic [ppf_pkg::GRAD_QB:0]   gr_dn [3];
	logic [ppf_pkg::DENS_QB-1:0] dens_q;
	logic                        dens_ovf;
	logic                        vld_q [T_DN];

	// Output combine.
	logic                     fault_c;
	logic [GW-1:0]            pot_mag;
	logic [GW:0]              term [3];
	logic signed [ACC_W-1:0]  sterm [3];
	logic signed [ACC_W-1:0]  acc [3];
	logic signed [GW-1:0]     gout [3];
	logic                     neg_dn [3];
	logic signed [GW-1:0]     gin_dn [3];
	ppf_pkg::out_word_t       res_c;
	ppf_pkg::out_word_t       result_q;
	logic                     done_q;

	// Configuration port: always ready, index beyond the list writes no register.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q   <= ppf_pkg::CFG_RESET;
			mass_q   <= ppf_pkg::CFG_RESET;
			scale_q  <= ppf_pkg::CFG_RESET;
			settle_q <= ppf_pkg::SETTLE_W'(ppf_pkg::CFG_SETTLE);
		end else begin
			if (cfg_wr) begin
				settle_q <= ppf_pkg::SETTLE_W'(ppf_pkg::CFG_SETTLE);
				if (cfg_index == ppf_pkg::CFG_GRAV) begin
					grav_q <= cfg_data;
				end
				if (cfg_index == ppf_pkg::CFG_MASS) begin
					mass_q <= cfg_data;
				end
				if (cfg_index == ppf_pkg::CFG_SCALE) begin
					scale_q <= cfg_data;
				end
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
		end
	end

	assign busy   = (settle_q != '0);
	assign accept = start & ~busy;

	// Constants derived from the configuration.
	ppf_mul #(.AW(ppf_pkg::CFG_W), .BW(ppf_pkg::CFG_W)) u_gm (
		.clk(clk), .a(grav_q), .b(mass_q), .p(gm)
	);
	ppf_mul #(.AW(ppf_pkg::CFG_W), .BW(ppf_pkg::CFG_W)) u_km (
		.clk(clk), .a(ppf_pkg::DENS_K), .b(mass_q), .p(km)
	);
	ppf_mul #(.AW(ppf_pkg::CFG_W), .BW(ppf_pkg::CFG_W)) u_b2 (
		.clk(clk), .a(scale_q), .b(scale_q), .p(b2)
	);
	ppf_mul #(.AW(ppf_pkg::GM_W), .BW(ppf_pkg::GM_W)) u_kmb2 (
		.clk(clk), .a(km), .b(b2), .p(kmb2)
	);

	// Stage 1: coordinate magnitudes and signs.
	assign pos_c[0] = operand.pos_x;
	assign pos_c[1] = operand.pos_y;
	assign pos_c[2] = operand.pos_z;
	assign gin_c[0] = operand.grad_in_x;
	assign gin_c[1] = operand.grad_in_y;
	assign gin_c[2] = operand.grad_in_z;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			neg_s1[k] <= pos_c[k][W-1];
			mag_s1[k] <= pos_c[k][W-1] ? W'(~pos_c[k] + W'(1)) : W'(pos_c[k]);
			gin_s1[k] <= gin_c[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < T_DN; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= accept;
			for (int i = 1; i < T_DN; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign side_in = {neg_s1[0], neg_s1[1], neg_s1[2], gin_s1[0], gin_s1[1], gin_s1[2]};

	ppf_dly #(.W(SIDE_W), .DEPTH(T_DN - 1)) u_side_dly (
		.clk(clk), .d(side_in), .q(side_dn)
	);

	// Squares and gradient numerators per axis.
	for (genvar k = 0; k < 3; k++) begin : g_axis
		ppf_mul #(.AW(W), .BW(W)) u_sq (
			.clk(clk), .a(mag_s1[k]), .b(mag_s1[k]), .p(sq[k])
		);
		ppf_mul #(.AW(ppf_pkg::GM_W), .BW(W)) u_gmx (
			.clk(clk), .a(gm), .b(mag_s1[k]), .p(gmx[k])
		);
		ppf_dly #(.W(ppf_pkg::GMX_W), .DEPTH(T_D1 - T_GMX)) u_gmx_dly (
			.clk(clk), .d(gmx[k]), .q(gmx_d1[k])
		);
		ppf_div #(.NW(ppf_pkg::GRAD_NUM_W), .DW(ppf_pkg::D1_W), .QB(ppf_pkg::GRAD_QB)) u_gdiv (
			.clk(clk),
			.num({gmx_d1[k], {ppf_pkg::GRAD_SHIFT{1'b0}}}),
			.den(d1),
			.quo(gr_q[k]),
			.ovf(gr_ovf[k])
		);
		ppf_dly #(.W(ppf_pkg::GRAD_QB + 1), .DEPTH(T_DN - T_GR)) u_gr_dly (
			.clk(clk), .d({gr_ovf[k], gr_q[k]}), .q(gr_dn[k])
		);
	end

	// r2 + b2, and the zero-divisor flag.
	assign sum_c = ppf_pkg::SUM_W'(sq[0]) + ppf_pkg::SUM_W'(sq[1]) +
		ppf_pkg::SUM_W'(sq[2]) + ppf_pkg::SUM_W'(b2);

	always_ff @(posedge clk) begin
		sum_s5  <= sum_c;
		zero_s5 <= (sum_c == '0);
	end

	ppf_dly #(.W(1), .DEPTH(T_DN - T_S)) u_zero_dly (
		.clk(clk), .d(zero_s5), .q(zero_dn)
	);

	// sqrt(r2 + b2) in Q.16.
	ppf_sqrt #(.IW(ppf_pkg::SUM_W), .SHIFT(ppf_pkg::ROOT_SHIFT), .RW(ppf_pkg::ROOT_W)) u_sqrt (
		.clk(clk), .s(sum_s5), .root(root)
	);

	// Potential magnitude G*m / sqrt.
	ppf_div #(.NW(ppf_pkg::POT_NUM_W), .DW(ppf_pkg::ROOT_W), .QB(ppf_pkg::POT_QB)) u_pdiv (
		.clk(clk),
		.num({gm, {ppf_pkg::POT_SHIFT{1'b0}}}),
		.den(root),
		.quo(pot_q),
		.ovf(pot_ovf)
	);
	ppf_dly #(.W(ppf_pkg::POT_QB + 1), .DEPTH(T_DN - T_POT)) u_pot_dly (
		.clk(clk), .d({pot_ovf, pot_q}), .q(pot_dn)
	);

	// Denominators S*Q and S*S*Q.
	ppf_dly #(.W(ppf_pkg::SUM_W), .DEPTH(T_Q - T_S)) u_sum_dly_q (
		.clk(clk), .d(sum_s5), .q(sum_q_al)
	);
	ppf_mul #(.AW(ppf_pkg::SUM_W), .BW(ppf_pkg::ROOT_W)) u_d1 (
		.clk(clk), .a(sum_q_al), .b(root), .p(d1)
	);
	ppf_dly #(.W(ppf_pkg::SUM_W), .DEPTH(T_D1 - T_Q)) u_sum_dly_d1 (
		.clk(clk), .d(sum_q_al), .q(sum_d1_al)
	);
	ppf_mul #(.AW(ppf_pkg::D1_W), .BW(ppf_pkg::SUM_W)) u_d2 (
		.clk(clk), .a(d1), .b(sum_d1_al), .p(d2)
	);

	// Density K*m*b2 / (S^2 * Q).
	ppf_div #(.NW(ppf_pkg::DENS_NUM_W), .DW(ppf_pkg::D2_W), .QB(ppf_pkg::DENS_QB)) u_ddiv (
		.clk(clk),
		.num({kmb2, {ppf_pkg::DENS_SHIFT{1'b0}}}),
		.den(d2),
		.quo(dens_q),
		.ovf(dens_ovf)
	);

	// Unpack side data at the last stage.
	assign neg_dn[0] = side_dn[SIDE_W-1];
	assign neg_dn[1] = side_dn[SIDE_W-2];
	assign neg_dn[2] = side_dn[SIDE_W-3];
	assign gin_dn[0] = side_dn[3*GW-1 -: GW];
	assign gin_dn[1] = side_dn[2*GW-1 -: GW];
	assign gin_dn[2] = side_dn[GW-1 -: GW];

	// Saturation, fault handling and gradient accumulation.
	always_comb begin
		fault_c = zero_dn | (scale_q == '0);
		pot_mag = (zero_dn | pot_dn[ppf_pkg::POT_QB]) ? ppf_pkg::POT_LIMIT
			: GW'(pot_dn[ppf_pkg::POT_QB-1:0]);
		for (int k = 0; k < 3; k++) begin
			term[k]  = gr_dn[k][ppf_pkg::GRAD_QB] ? ppf_pkg::TERM_LIMIT
				: (GW + 1)'(gr_dn[k][ppf_pkg::GRAD_QB-1:0]);
			sterm[k] = neg_dn[k] ? -$signed({1'b0, term[k]}) : $signed({1'b0, term[k]});
			acc[k]   = ACC_W'(gin_dn[k]) + sterm[k];
			if (zero_dn) begin
				gout[k] = gin_dn[k];
			end else if (acc[k] > ACC_W'(ppf_pkg::GRAD_MAX)) begin
				gout[k] = ppf_pkg::GRAD_MAX;
			end else if (acc[k] < ACC_W'(ppf_pkg::GRAD_MIN)) begin
				gout[k] = ppf_pkg::GRAD_MIN;
			end else begin
				gout[k] = acc[k][GW-1:0];
			end
		end
		res_c.potential  = $signed(-pot_mag);
		res_c.grad_out_x = gout[0];
		res_c.grad_out_y = gout[1];
		res_c.grad_out_z = gout[2];
		res_c.density    = (fault_c | dens_ovf) ? '1 : dens_q;
		res_c.div_fault  = fault_c;
	end

	// Output register.
	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[T_DN-1];
		end
	end

	assign result = result_q;
	assign done   = done_q;

	// A configuration write holds off new words while the constants settle.
	`ASSERT_NEXT(a_cfg_busy, clk, arst_n, cfg_valid && cfg_ready, busy)
	// The potential is never positive.
	`ASSERT_IMPLIES(a_pot_sign, clk, arst_n, done, result.potential[GW-1] || result.potential == '0)
	// A flagged word always carries a saturated density.
	`ASSERT_IMPLIES(a_dens_sat, clk, arst_n, done && result.div_fault, result.density == '1)

endmodule

[dv/ppf_checker.sv]
// Checker that predicts and compares every result word of the Plummer sphere evaluator.
module ppf_checker
	import ppf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  in_word_t             operand,
	input  logic                 done,
	input  out_word_t            result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CFG_W-1:0] g_reg, m_reg, b_reg;
	out_word_t        expected_words[$];

	// Predict one result word from one input word and the current registers.
	function automatic out_word_t plummer_eval(in_word_t w);
		logic [COORD_WIDTH-1:0]        mag[3];
		logic                          neg[3];
		logic signed [COORD_WIDTH-1:0] c[3];
		logic signed [GRAD_W-1:0]      gi[3];
		logic [255:0]                  s, t, gm, root, cand, num, den, q;
		logic [GRAD_W:0]               term;
		logic [GRAD_W-1:0]             pmag;
		logic signed [GRAD_W+2:0]      acc;
		out_word_t                     r;
		c[0] = w.pos_x;
		c[1] = w.pos_y;
		c[2] = w.pos_z;
		gi[0] = w.grad_in_x;
		gi[1] = w.grad_in_y;
		gi[2] = w.grad_in_z;
		r.div_fault = (b_reg == 0);
		s = 256'(b_reg) * 256'(b_reg);
		for (int k = 0; k < 3; k++) begin
			neg[k] = c[k][COORD_WIDTH-1];
			mag[k] = neg[k] ? (~c[k] + 1'b1) : c[k];
			s = s + 256'(mag[k]) * 256'(mag[k]);
		end
		gm = 256'(g_reg) * 256'(m_reg);
		if (s == 0) begin
			// Origin with zero core length: force is zero, the rest saturates.
			r.div_fault = 1'b1;
			r.potential = POT_LIMIT;
			r.grad_out_x = gi[0];
			r.grad_out_y = gi[1];
			r.grad_out_z = gi[2];
			r.density = '1;
			return r;
		end
		// Integer square root of r2 + b2 in Q.16.
		t = s << 32;
		root = 0;
		for (int i = 63; i >= 0; i--) begin
			cand = root | (256'd1 << i);
			if (cand * cand <= t)
				root = cand;
		end
		// Potential magnitude, clamped to 2^47 and negated.
		q = (gm << 16) / root;
		pmag = (q > 256'(POT_LIMIT)) ? POT_LIMIT : q[GRAD_W-1:0];
		r.potential = -pmag;
		// Gradient terms added to the incoming gradient with saturation.
		den = s * root;
		for (int k = 0; k < 3; k++) begin
			q = ((gm * 256'(mag[k])) << 32) / den;
			term = (q > 256'(TERM_LIMIT)) ? TERM_LIMIT : q[GRAD_W:0];
			acc = gi[k];
			if (neg[k])
				acc = acc - $signed({2'b0, term});
			else
				acc = acc + $signed({2'b0, term});
			if (acc > GRAD_MAX)
				acc = GRAD_MAX;
			if (acc < GRAD_MIN)
				acc = GRAD_MIN;
			case (k)
				0: r.grad_out_x = acc[GRAD_W-1:0];
				1: r.grad_out_y = acc[GRAD_W-1:0];
				default: r.grad_out_z = acc[GRAD_W-1:0];
			endcase
		end
		// Density, saturated; forced to all ones when the core length is zero.
		if (r.div_fault) begin
			r.density = '1;
		end else begin
			num = ((256'(DENS_K) * 256'(m_reg) * 256'(b_reg) * 256'(b_reg)) << 48);
			q = num / (s * s * root);
			r.density = (q > 256'({GRAD_W{1'b1}})) ? '1 : q[GRAD_W-1:0];
		end
		return r;
	endfunction

	// Track register writes, queue predictions and compare result words.
	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			g_reg <= CFG_RESET;
			m_reg <= CFG_RESET;
			b_reg <= CFG_RESET;
			errors = 0;
			expected_words.delete();
		end else begin
			if (done) begin
				if (expected_words.size() == 0) begin
					$error("result word with no prediction waiting");
					errors++;
				end else begin
					e = expected_words.pop_front();
					if (result.potential !== e.potential) begin
						$error("potential exp %h got %h", e.potential, result.potential);
						errors++;
					end
					if (result.grad_out_x !== e.grad_out_x) begin
						$error("grad_out_x exp %h got %h", e.grad_out_x, result.grad_out_x);
						errors++;
					end
					if (result.grad_out_y !== e.grad_out_y) begin
						$error("grad_out_y exp %h got %h", e.grad_out_y, result.grad_out_y);
						errors++;
					end
					if (result.grad_out_z !== e.grad_out_z) begin
						$error("grad_out_z exp %h got %h", e.grad_out_z, result.grad_out_z);
						errors++;
					end
					if (result.density !== e.density) begin
						$error("density exp %h got %h", e.density, result.density);
						errors++;
					end
					if (result.div_fault !== e.div_fault) begin
						$error("div_fault exp %b got %b", e.div_fault, result.div_fault);
						errors++;
					end
				end
			end
			if (start && !busy)
				expected_words.push_back(plummer_eval(operand));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GRAV:  g_reg <= cfg_data;
					CFG_MASS:  m_reg <= cfg_data;
					CFG_SCALE: b_reg <= cfg_data;
					default: ;
				endcase
			end
		end
		// Number of predictions still waiting for their result word.
		pending = expected_words.size();
	end

endmodule

[dv/testbench.sv]
// Top of the Plummer sphere evaluator testbench: stimulus, register phases and verdict.
module testbench;
	import ppf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                   LATENCY    = 120;
	localparam int                   CYCLE_MAX  = 400000;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	in_word_t             operand;
	logic                 done;
	out_word_t            result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;
	int                   cycles;

	plummer_potential_force_eval uut (.*);

	ppf_checker checker_i (.*);

	// Free-running clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_MAX) begin
			$display("plummer_potential_force_eval test failed");
			$finish;
		end
	end

	// Present one word and hold it until the block takes it.
	task automatic send_word(in_word_t w);
		logic b;
		start <= 1'b1;
		operand <= w;
		do begin
			b = busy;
			@(negedge clk);
		end while (b);
	endtask

	// Idle gap after a word: mostly none, sometimes short, rarely long.
	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 99);
		if (n < 55)
			return;
		start <= 1'b0;
		operand <= '0;
		repeat ((n < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clk);
	endtask

	// Register write through the configuration channel.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		logic r;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do begin
			r = cfg_ready;
			@(negedge clk);
		end while (!r);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every predicted word has come back and the pipeline is empty.
	task automatic drain();
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $signed(COORD_WIDTH'($urandom_range(0, 1 << 21))) - (1 << 20);
			4, 5, 6: return $urandom;
			7: return '0;
			8: return $urandom_range(0, 1) ? {1'b0, {(COORD_WIDTH - 1){1'b1}}}
				: {1'b1, {(COORD_WIDTH - 1){1'b0}}};
			default: return $signed(COORD_WIDTH'($urandom_range(0, 1 << 18))) - (1 << 17);
		endcase
	endfunction

	function automatic logic signed [GRAD_W-1:0] rand_grad();
		case ($urandom_range(0, 5))
			0, 1: return GRAD_W'({$urandom, $urandom});
			2: return $urandom_range(0, 1) ? GRAD_MAX : GRAD_MIN;
			3: return '0;
			default: return $signed(GRAD_W'($urandom_range(0, 1 << 24))) - (1 << 23);
		endcase
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		w.pos_x = rand_coord();
		w.pos_y = rand_coord();
		w.pos_z = rand_coord();
		w.grad_in_x = rand_grad();
		w.grad_in_y = rand_grad();
		w.grad_in_z = rand_grad();
		return w;
	endfunction

	function automatic in_word_t make_word(logic signed [COORD_WIDTH-1:0] x, y, z,
			logic signed [GRAD_W-1:0] g);
		in_word_t w;
		w.pos_x = x;
		w.pos_y = y;
		w.pos_z = z;
		w.grad_in_x = g;
		w.grad_in_y = -g;
		w.grad_in_z = g;
		return w;
	endfunction

	initial begin
		logic signed [COORD_WIDTH-1:0] cmax, cmin;
		cmax = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
		cmin = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operand = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 6; phase++) begin
			// Register settings of this phase, extremes first.
			case (phase)
				1: begin
					write_reg(CFG_GRAV, '1);
					write_reg(CFG_MASS, '1);
					write_reg(CFG_SCALE, '1);
				end
				2: begin
					write_reg(CFG_GRAV, $urandom);
					write_reg(CFG_MASS, $urandom);
					write_reg(CFG_SCALE, '0);
				end
				3: begin
					write_reg(CFG_GRAV, '0);
					write_reg(CFG_MASS, $urandom_range(1, 1 << 20));
					write_reg(CFG_SCALE, 32'd1);
					write_reg(CFG_UNUSED, $urandom);
				end
				4: begin
					write_reg(CFG_GRAV, $urandom_range(1 << 12, 1 << 20));
					write_reg(CFG_MASS, $urandom_range(1 << 12, 1 << 20));
					write_reg(CFG_SCALE, $urandom_range(1 << 10, 1 << 20));
				end
				5: begin
					write_reg(CFG_GRAV, $urandom);
					write_reg(CFG_MASS, $urandom);
					write_reg(CFG_SCALE, $urandom);
				end
				default: ;
			endcase

			// Directed words: origin, coordinate and gradient extremes.
			if (phase == 0 || phase == 1 || phase == 2) begin
				send_word(make_word(0, 0, 0, 0));
				send_word(make_word(0, 0, 0, GRAD_MAX));
				send_word(make_word(cmax, cmax, cmax, GRAD_MAX));
				send_word(make_word(cmin, cmin, cmin, GRAD_MIN));
				send_word(make_word(cmin, cmax, 0, GRAD_MIN));
				send_word(make_word(32'sd1, -32'sd1, 0, 0));
				send_word(make_word(32'sd65536, 0, 0, GRAD_MAX));
				send_word(make_word(0, -32'sd65536, 0, GRAD_MIN));
			end

			// Random words with gaps; in phase 4 the sender pauses for a full drain midway.
			for (int i = 0; i < 75; i++) begin
				send_word(rand_word());
				idle_gap();
				if (i == 40 && phase == 4)
					drain();
			end
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("plummer_potential_force_eval test passed");
		else
			$display("plummer_potential_force_eval test failed");
		$finish;
	end

endmodule
